// ----- hdl/vmclp_pkg.sv -----
`timescale 1ns / 1ps
// Types, constants and character/keyword helpers for the VM command line parser.
package vmclp_pkg;

  localparam int MAX_KEYWORD_CHARS = 8;
  localparam int ARG2_BITS         = 16;
  localparam int LINE_BITS         = 16;

  localparam int NUM_CMDS  = 17;
  localparam int CMD_W     = 5;
  localparam int KL_W      = $clog2(MAX_KEYWORD_CHARS + 2);
  localparam int KI_W      = $clog2(MAX_KEYWORD_CHARS);
  localparam int WORD_MAX  = 8;
  localparam int KW_CMP    = (MAX_KEYWORD_CHARS < WORD_MAX) ? MAX_KEYWORD_CHARS : WORD_MAX;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int TDATA_W   = 56;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef enum logic [3:0] {
    PH_FIRST, PH_LSTART, PH_KEY, PH_A1SKIP, PH_A1,
    PH_A2SKIP, PH_A2, PH_LEND, PH_WANTLF, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHAR, KIND_RECORD, KIND_ERROR, KIND_END
  } kind_t;

  typedef enum logic [1:0] {
    ERR_UNKNOWN, ERR_EMPTY_ARG, ERR_LINE_END
  } err_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD, CMD_SUB, CMD_NEG, CMD_EQ, CMD_GT, CMD_LT, CMD_AND, CMD_OR, CMD_NOT,
    CMD_PUSH, CMD_POP, CMD_LABEL, CMD_GOTO, CMD_IFGOTO, CMD_FUNCTION,
    CMD_RETURN, CMD_CALL
  } cmd_t;

  typedef logic [MAX_KEYWORD_CHARS-1:0][7:0] kw_t;

  typedef struct packed {
    logic             hit;
    logic [CMD_W-1:0] code;
  } lookup_t;

  typedef struct packed {
    kind_t            kind;
    logic [CMD_W-1:0] command;
    logic [7:0]       arg1_char;
    logic [7:0]       arg1_length;
    logic [15:0]      arg2_value;
    logic [15:0]      line_number;
    err_t             error_code;
  } res_t;

  // Keywords are spelled backwards so the first character lands in the low byte.
  function automatic logic [63:0] cmd_word(logic [CMD_W-1:0] k);
    case (k)
      CMD_ADD:      cmd_word = 64'("dda");
      CMD_SUB:      cmd_word = 64'("bus");
      CMD_NEG:      cmd_word = 64'("gen");
      CMD_EQ:       cmd_word = 64'("qe");
      CMD_GT:       cmd_word = 64'("tg");
      CMD_LT:       cmd_word = 64'("tl");
      CMD_AND:      cmd_word = 64'("dna");
      CMD_OR:       cmd_word = 64'("ro");
      CMD_NOT:      cmd_word = 64'("ton");
      CMD_PUSH:     cmd_word = 64'("hsup");
      CMD_POP:      cmd_word = 64'("pop");
      CMD_LABEL:    cmd_word = 64'("lebal");
      CMD_GOTO:     cmd_word = 64'("otog");
      CMD_IFGOTO:   cmd_word = 64'("otog-fi");
      CMD_FUNCTION: cmd_word = 64'("noitcnuf");
      CMD_RETURN:   cmd_word = 64'("nruter");
      CMD_CALL:     cmd_word = 64'("llac");
      default:      cmd_word = '0;
    endcase
  endfunction

  function automatic logic [3:0] cmd_len(logic [CMD_W-1:0] k);
    case (k)
      CMD_EQ, CMD_GT, CMD_LT, CMD_OR:                     cmd_len = 4'd2;
      CMD_ADD, CMD_SUB, CMD_NEG, CMD_AND, CMD_NOT, CMD_POP: cmd_len = 4'd3;
      CMD_PUSH, CMD_GOTO, CMD_CALL:                       cmd_len = 4'd4;
      CMD_LABEL:                                          cmd_len = 4'd5;
      CMD_RETURN:                                         cmd_len = 4'd6;
      CMD_IFGOTO:                                         cmd_len = 4'd7;
      CMD_FUNCTION:                                       cmd_len = 4'd8;
      default:                                            cmd_len = 4'd0;
    endcase
  endfunction

  function automatic logic [1:0] cmd_nargs(logic [CMD_W-1:0] k);
    case (k)
      CMD_PUSH, CMD_POP, CMD_FUNCTION, CMD_CALL: cmd_nargs = 2'd2;
      CMD_LABEL, CMD_GOTO, CMD_IFGOTO:          cmd_nargs = 2'd1;
      default:                                  cmd_nargs = 2'd0;
    endcase
  endfunction

  // Lowest command index wins; the words are distinct anyway.
  function automatic lookup_t cmd_lookup(kw_t kw, logic [KL_W-1:0] len);
    lookup_t     r;
    logic        same;
    logic [63:0] w;
    r = '0;
    for (int k = NUM_CMDS - 1; k >= 0; k--) begin
      w = cmd_word(CMD_W'(k));
      same = (int'(cmd_len(CMD_W'(k))) == int'(len)) &&
             (int'(len) <= MAX_KEYWORD_CHARS);
      for (int i = 0; i < KW_CMP; i++) begin
        if (i < int'(len) && kw[i] != w[8*i +: 8]) same = 1'b0;
      end
      if (same) begin
        r.hit  = 1'b1;
        r.code = CMD_W'(k);
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  function automatic logic is_key(logic [7:0] c);
    logic [7:0] l;
    l = to_lower(c);
    return (l >= "a" && l <= "z") || l == "-";
  endfunction

  function automatic logic is_a1(logic [7:0] c);
    logic [7:0] l;
    l = to_lower(c);
    return (l >= "a" && l <= "z") || l == "_" || l == ".";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic res_t make_res(kind_t kind, logic [CMD_W-1:0] cmd, logic [7:0] ch,
                                    logic [7:0] len, logic [15:0] a2,
                                    logic [15:0] ln, err_t err);
    res_t r;
    r.kind        = kind;
    r.command     = cmd;
    r.arg1_char   = ch;
    r.arg1_length = len;
    r.arg2_value  = a2;
    r.line_number = ln;
    r.error_code  = err;
    return r;
  endfunction

  function automatic res_t make_record(logic [CMD_W-1:0] cmd, logic [7:0] a1,
                                       logic [15:0] a2, logic [15:0] ln);
    logic [1:0] argc;
    argc = cmd_nargs(cmd);
    return make_res(KIND_RECORD, cmd, 8'd0, (argc != 2'd0) ? a1 : 8'd0,
                    (argc == 2'd2) ? a2 : 16'd0, ln, ERR_UNKNOWN);
  endfunction

endpackage

// ----- hdl/vm_command_line_parser.sv -----
`timescale 1ns / 1ps
// VM command line parser: byte-stream keyword/argument parser with a result queue.
//
// Input channel s_*: one text byte per word in s_tdata; a zero byte ends the text.
// Output channel m_*: result words; m_tuser is the kind (arg1 character, command
// record, error, end of text), m_tdata carries the record fields.
// Each accepted byte is parsed in the cycle it arrives and its results (zero,
// one or two words) are written into a 4-entry queue at that clock edge, so a
// result can reach m_tvalid no sooner than the cycle after its byte is accepted.
// Throughput is one byte per cycle while the sink keeps up. A byte that closes
// the last field of a command and is itself a NUL or an illegal character
// produces two words (record, then end or error).
// s_tready is high while at least two queue entries are free; when the sink
// stalls, the queue fills and s_tready drops until words are taken.
// Reset empties the queue, sets the line count to one and arms the first-line
// blank skip. After an error or the end of text every further byte is
// accepted and dropped until the next reset.
module vm_command_line_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [vmclp_pkg::TDATA_W-1:0] m_tdata,
  // [4:0] command, [12:5] arg1_char, [20:13] arg1_length, [36:21] arg2_value,
  // [52:37] line_number, [54:53] error_code, [55] zero
  output logic [1:0]  m_tuser    // [1:0] kind
);
  import vmclp_pkg::*;

  phase_t                 phase, phase_next;
  kw_t                    kw, kw_next;
  logic [KL_W-1:0]        kw_len, kw_len_next;
  logic [CMD_W-1:0]       cmd_code, cmd_code_next;
  logic [7:0]             arg1_cnt, arg1_cnt_next;
  logic [ARG2_BITS-1:0]   arg2_acc, arg2_acc_next;
  logic [LINE_BITS-1:0]   line_cnt, line_cnt_next;
  logic                   halted, halted_next;

  res_t                   res_next [2];
  logic [1:0]             n_res;
  logic [1:0]             n_push;
  logic                   in_fire, out_fire;

  res_t                   fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]       wr_ptr, rd_ptr;
  logic [CNT_W-1:0]       cnt;

  logic [7:0]             c;
  lookup_t                hit;
  logic [ARG2_BITS+3:0]   a2_wide;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign s_tready = cnt <= CNT_W'(FIFO_DEPTH - 2);
  assign n_push   = in_fire ? n_res : 2'd0;

  // Phases are visited in a fixed order within one byte, so each block below
  // sees the phase left by the blocks above it.
  always_comb begin
    phase_next    = phase;
    kw_next       = kw;
    kw_len_next   = kw_len;
    cmd_code_next = cmd_code;
    arg1_cnt_next = arg1_cnt;
    arg2_acc_next = arg2_acc;
    line_cnt_next = line_cnt;
    halted_next   = halted;
    res_next[0]   = '0;
    res_next[1]   = '0;
    n_res         = 2'd0;
    c             = s_tdata;
    hit           = '0;
    a2_wide       = '0;

    if (!halted) begin
      if (phase_next == PH_FIRST || phase_next == PH_LSTART) begin
        if (phase_next == PH_FIRST && is_blank(c)) begin
        end else if (c == CH_NUL) begin
          res_next[n_res[0]] = make_res(KIND_END, '0, 8'd0, 8'd0, 16'd0,
                                        16'(line_cnt_next), ERR_UNKNOWN);
          n_res = n_res + 2'd1;
          halted_next = 1'b1;
          phase_next = PH_DONE;
        end else if (c == CH_CR) begin
          phase_next = PH_WANTLF;
        end else if (c == CH_LF) begin
          if (line_cnt_next != '1) line_cnt_next = line_cnt_next + LINE_BITS'(1);
          phase_next = PH_LSTART;
        end else begin
          kw_len_next = '0;
          phase_next = PH_KEY;
        end
      end

      if (phase_next == PH_KEY) begin
        if (is_key(c)) begin
          if (kw_len_next < KL_W'(MAX_KEYWORD_CHARS))
            kw_next[kw_len_next[KI_W-1:0]] = to_lower(c);
          if (kw_len_next <= KL_W'(MAX_KEYWORD_CHARS))
            kw_len_next = kw_len_next + KL_W'(1);
        end else begin
          hit = cmd_lookup(kw_next, kw_len_next);
          if (!hit.hit) begin
            res_next[n_res[0]] = make_res(KIND_ERROR, '0, 8'd0, 8'd0, 16'd0,
                                          16'(line_cnt_next), ERR_UNKNOWN);
            n_res = n_res + 2'd1;
            halted_next = 1'b1;
            phase_next = PH_DONE;
          end else begin
            cmd_code_next = hit.code;
            arg1_cnt_next = 8'd0;
            arg2_acc_next = '0;
            if (cmd_nargs(hit.code) == 2'd0) begin
              res_next[n_res[0]] = make_record(cmd_code_next, arg1_cnt_next,
                                               16'(arg2_acc_next), 16'(line_cnt_next));
              n_res = n_res + 2'd1;
              phase_next = PH_LEND;
            end else begin
              phase_next = PH_A1SKIP;
            end
          end
        end
      end

      if (phase_next == PH_A1SKIP) begin
        if (is_blank(c)) begin
        end else if (!is_a1(c)) begin
          res_next[n_res[0]] = make_res(KIND_ERROR, '0, 8'd0, 8'd0, 16'd0,
                                        16'(line_cnt_next), ERR_EMPTY_ARG);
          n_res = n_res + 2'd1;
          halted_next = 1'b1;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_A1;
        end
      end

      if (phase_next == PH_A1) begin
        if (is_a1(c)) begin
          res_next[n_res[0]] = make_res(KIND_CHAR, cmd_code_next, c, 8'd0, 16'd0,
                                        16'(line_cnt_next), ERR_UNKNOWN);
          n_res = n_res + 2'd1;
          if (arg1_cnt_next != 8'hFF) arg1_cnt_next = arg1_cnt_next + 8'd1;
        end else if (cmd_nargs(cmd_code_next) == 2'd2) begin
          phase_next = PH_A2SKIP;
        end else begin
          res_next[n_res[0]] = make_record(cmd_code_next, arg1_cnt_next,
                                           16'(arg2_acc_next), 16'(line_cnt_next));
          n_res = n_res + 2'd1;
          phase_next = PH_LEND;
        end
      end

      if (phase_next == PH_A2SKIP) begin
        if (is_blank(c)) begin
        end else if (!is_digit(c)) begin
          res_next[n_res[0]] = make_res(KIND_ERROR, '0, 8'd0, 8'd0, 16'd0,
                                        16'(line_cnt_next), ERR_EMPTY_ARG);
          n_res = n_res + 2'd1;
          halted_next = 1'b1;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_A2;
        end
      end

      if (phase_next == PH_A2) begin
        if (is_digit(c)) begin
          // acc * 10 + digit, as two shifts and adds
          a2_wide = {arg2_acc_next, 3'b000} + {1'b0, arg2_acc_next, 1'b0} +
                    (ARG2_BITS+4)'(c - "0");
          arg2_acc_next = (a2_wide > {4'b0000, {ARG2_BITS{1'b1}}}) ?
                          {ARG2_BITS{1'b1}} : a2_wide[ARG2_BITS-1:0];
        end else begin
          res_next[n_res[0]] = make_record(cmd_code_next, arg1_cnt_next,
                                           16'(arg2_acc_next), 16'(line_cnt_next));
          n_res = n_res + 2'd1;
          phase_next = PH_LEND;
        end
      end

      if (phase_next == PH_LEND) begin
        if (is_blank(c)) begin
        end else if (c == CH_NUL) begin
          res_next[n_res[0]] = make_res(KIND_END, '0, 8'd0, 8'd0, 16'd0,
                                        16'(line_cnt_next), ERR_UNKNOWN);
          n_res = n_res + 2'd1;
          halted_next = 1'b1;
          phase_next = PH_DONE;
        end else if (c == CH_CR) begin
          phase_next = PH_WANTLF;
        end else if (c == CH_LF) begin
          if (line_cnt_next != '1) line_cnt_next = line_cnt_next + LINE_BITS'(1);
          phase_next = PH_LSTART;
        end else begin
          res_next[n_res[0]] = make_res(KIND_ERROR, '0, 8'd0, 8'd0, 16'd0,
                                        16'(line_cnt_next), ERR_LINE_END);
          n_res = n_res + 2'd1;
          halted_next = 1'b1;
          phase_next = PH_DONE;
        end
      end

      // only a CR seen on an earlier byte gets here
      if (phase == PH_WANTLF) begin
        if (c == CH_LF) begin
          if (line_cnt_next != '1) line_cnt_next = line_cnt_next + LINE_BITS'(1);
          phase_next = PH_LSTART;
        end else begin
          res_next[n_res[0]] = make_res(KIND_ERROR, '0, 8'd0, 8'd0, 16'd0,
                                        16'(line_cnt_next), ERR_LINE_END);
          n_res = n_res + 2'd1;
          halted_next = 1'b1;
          phase_next = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_FIRST;
      kw       <= '0;
      kw_len   <= '0;
      cmd_code <= '0;
      arg1_cnt <= '0;
      arg2_acc <= '0;
      line_cnt <= LINE_BITS'(1);
      halted   <= 1'b0;
    end else if (in_fire) begin
      phase    <= phase_next;
      kw       <= kw_next;
      kw_len   <= kw_len_next;
      cmd_code <= cmd_code_next;
      arg1_cnt <= arg1_cnt_next;
      arg2_acc <= arg2_acc_next;
      line_cnt <= line_cnt_next;
      halted   <= halted_next;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) fifo[wr_ptr] <= res_next[0];
    if (n_push == 2'd2) fifo[wr_ptr + PTR_W'(1)] <= res_next[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      if (out_fire) rd_ptr <= rd_ptr + PTR_W'(1);
      cnt <= cnt + CNT_W'(n_push) - CNT_W'(out_fire);
    end
  end

  assign m_tvalid = cnt != '0;
  assign m_tuser  = fifo[rd_ptr].kind;
  assign m_tdata  = {1'b0, fifo[rd_ptr].error_code, fifo[rd_ptr].line_number,
                     fifo[rd_ptr].arg2_value, fifo[rd_ptr].arg1_length,
                     fifo[rd_ptr].arg1_char, fifo[rd_ptr].command};

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt flag cleared without reset");

  a_done_halted: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) == halted)
    else $error("done phase and halt flag disagree");

  a_quiet_halted: assert property (@(posedge clk) disable iff (rst)
    halted |-> n_res == 2'd0)
    else $error("word produced after halt");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_cnt != '0)
    else $error("line count wrapped to zero");

endmodule
